// File: design/poarl_pkg.sv
// ----------------------------------------------------------------------------
// poarl_pkg: shared types and constants of the PWM arming ramp limiter
// Mode codes, field widths, register indexes and the front-to-back item.
// ----------------------------------------------------------------------------
`default_nettype none
package poarl_pkg;
	localparam int MAX_CHANNELS_DEF = 16;
	localparam int PROGRESS_FULL    = 10000;

	// floor(x / 10000) == ((x >> 4) * PROG_RECIP) >> PROG_RECIP_SHIFT for x < 2^30
	localparam logic [26:0] PROG_RECIP       = 27'd109951163;
	localparam int          PROG_RECIP_SHIFT = 36;

	typedef enum logic [1:0] {
		MODE_INIT = 2'd0,
		MODE_OFF  = 2'd1,
		MODE_RAMP = 2'd2,
		MODE_ON   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_REVERSE = 2'd0,
		REG_RAMP    = 2'd1,
		REG_INIT    = 2'd2,
		REG_NONE    = 2'd3
	} reg_idx_t;

	// back end sequencer
	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_LO1, ST_LO2, ST_LO3, ST_MUL, ST_FIN, ST_OUT
	} back_state_t;

	// item handed from front to back
	typedef struct packed {
		logic              start;
		logic              armed;
		logic              prearm;
		logic [31:0]       now_us;
		logic [3:0]        channel;
		logic signed [15:0] ctrl;
		logic              valid;
		logic [15:0]       dis;
		logic [15:0]       mn;
		logic [15:0]       mx;
	} item_t;
endpackage
`default_nettype wire

// File: design/pwm_output_arming_ramp_limiter.sv
// ----------------------------------------------------------------------------
// pwm_output_arming_ramp_limiter: PWM arming state machine and ramp mapper
// Turns Q1.15 channel controls into PWM words under an arming ramp.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one channel item per transfer; the item with frame_start
//  set steps the arming machine (init, off, ramp, on) using now_us.
//  m_axis returns one transfer per input: channel, PWM word, stored mode.
//  An ordinary channel item passes from IDLE through states LO1, LO2, LO3,
//  MUL, FIN and OUT; a frame start item first runs the 46-step serial
//  divider that computes ramp progress. The back end works one item at a
//  time, taking the next only after the output transfer, while the 2-entry
//  input queue keeps filling. A stalled receiver holds the result; the queue
//  then fills and s_axis_tready drops.
//  Reset: mode init, arm time unset, progress 0, registers at defaults
//  (reverse mask 0, ramp and init time 500000 us). The user writes registers
//  via cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none
module pwm_output_arming_ramp_limiter #(
	parameter int MAX_CHANNELS = poarl_pkg::MAX_CHANNELS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// frame_start, armed, prearm, now_us, channel, ctrl,
	// value_valid, disarmed_level, min_level, max_level (104 bits)
	input  wire  [103:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// out_channel, pwm_value, mode_now (22 bits, zero filled)
	output logic [23:0] m_axis_tdata,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [23:0] cfg_data
);
	logic [15:0] rev_bits_q;
	logic [23:0] ramp_time_q, init_time_q;
	poarl_pkg::item_t in_item, q_item;
	logic q_valid, q_take;
	logic [3:0]  out_channel;
	logic [15:0] pwm_value;
	logic [1:0]  mode_now;

	assign in_item.start     = s_axis_tdata[0];
	assign in_item.armed     = s_axis_tdata[1];
	assign in_item.prearm    = s_axis_tdata[2];
	assign in_item.now_us    = s_axis_tdata[34:3];
	assign in_item.channel   = s_axis_tdata[38:35];
	assign in_item.ctrl      = s_axis_tdata[54:39];
	assign in_item.valid     = s_axis_tdata[55];
	assign in_item.dis       = s_axis_tdata[71:56];
	assign in_item.mn        = s_axis_tdata[87:72];
	assign in_item.mx        = s_axis_tdata[103:88];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_bits_q  <= 16'd0;
			ramp_time_q <= 24'd500000;
			init_time_q <= 24'd500000;
		end else if (cfg_we) begin
			unique case (poarl_pkg::reg_idx_t'(cfg_index))
				poarl_pkg::REG_REVERSE: rev_bits_q  <= cfg_data[15:0];
				poarl_pkg::REG_RAMP:    ramp_time_q <= cfg_data;
				poarl_pkg::REG_INIT:    init_time_q <= cfg_data;
				default: ;
			endcase
		end
	end

	poarl_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
		.q_valid(q_valid), .q_take(q_take), .q_item(q_item)
	);

	poarl_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_take(q_take), .q_item(q_item),
		.rev_bits(rev_bits_q), .ramp_span(ramp_time_q),
		.init_span(init_time_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_channel(out_channel), .pwm_value(pwm_value), .mode_now(mode_now)
	);

	assign m_axis_tdata = {2'b00, mode_now, pwm_value, out_channel};
endmodule
`default_nettype wire

// File: design/poarl_front.sv
// ----------------------------------------------------------------------------
// poarl_front: input stage and queue
// Two-entry queue holding accepted input items for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module poarl_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire poarl_pkg::item_t in_item,
	output logic                q_valid,
	input  wire                 q_take,
	output poarl_pkg::item_t    q_item
);
	poarl_pkg::item_t ent_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// File: design/poarl_back.sv
// ----------------------------------------------------------------------------
// poarl_back: arming machine and PWM mapping sequencer
// Steps the mode per frame, derives ramp progress by a serial divider and
// maps the control value through states LO1 to FIN into a registered output.
// ----------------------------------------------------------------------------
`default_nettype none
module poarl_back #(
	parameter int MAX_CHANNELS = poarl_pkg::MAX_CHANNELS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              q_valid,
	output logic             q_take,
	input  wire poarl_pkg::item_t q_item,
	input  wire  [15:0]      rev_bits,
	input  wire  [23:0]      ramp_span,
	input  wire  [23:0]      init_span,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [3:0]       out_channel,
	output logic [15:0]      pwm_value,
	output logic [1:0]       mode_now
);
	poarl_pkg::back_state_t st_q, st_nx;
	poarl_pkg::item_t it_q;
	poarl_pkg::mode_t lmode_q, fmode_q;
	logic [31:0] arm_q;
	logic [13:0] prog_q;
	// serial divider for elapsed*10000/ramp
	logic [45:0] num_q;
	logic [23:0] rem_q;
	logic [5:0]  dcnt_q;
	logic [15:0] lo_q;
	logic [29:0] prod_q;
	logic [15:0] quo_q;
	logic signed [16:0] half_q;
	logic signed [16:0] v_q;
	logic signed [34:0] mul_q;
	logic [15:0] mid_q;

	// arming step for the item at the queue head
	logic [31:0] step_el, step_arm;
	poarl_pkg::mode_t step_mode;

	logic [15:0] d, diff;
	logic [24:0] rsh;
	logic        rev;
	logic [52:0] qprod;
	logic [31:0] res_tr;
	logic signed [35:0] numv;
	logic [35:0] mag;

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			poarl_pkg::ST_IDLE: if (q_valid) st_nx = q_item.start ? poarl_pkg::ST_DIV
			                                                     : poarl_pkg::ST_LO1;
			poarl_pkg::ST_DIV:  if (dcnt_q == 6'd0) st_nx = poarl_pkg::ST_LO1;
			poarl_pkg::ST_LO1:  st_nx = poarl_pkg::ST_LO2;
			poarl_pkg::ST_LO2:  st_nx = poarl_pkg::ST_LO3;
			poarl_pkg::ST_LO3:  st_nx = poarl_pkg::ST_MUL;
			poarl_pkg::ST_MUL:  st_nx = poarl_pkg::ST_FIN;
			poarl_pkg::ST_FIN:  st_nx = poarl_pkg::ST_OUT;
			poarl_pkg::ST_OUT:  if (out_ready) st_nx = poarl_pkg::ST_IDLE;
			default: st_nx = poarl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_take    = (st_q == poarl_pkg::ST_IDLE) && q_valid;
		out_valid = (st_q == poarl_pkg::ST_OUT);
	end

	// arming machine next state, arm time and elapsed time for progress
	always_comb begin
		step_el   = q_item.now_us - arm_q;
		step_arm  = arm_q;
		step_mode = lmode_q;
		unique case (lmode_q)
			poarl_pkg::MODE_INIT: if (q_item.armed) begin
				if (arm_q == 32'd0) begin
					step_arm = q_item.now_us;
					step_el  = 32'd0;
				end
				if (step_el >= {8'd0, init_span}) step_mode = poarl_pkg::MODE_OFF;
			end
			poarl_pkg::MODE_OFF: if (q_item.armed) begin
				step_mode = poarl_pkg::MODE_RAMP;
				step_arm  = q_item.now_us;
				step_el   = 32'd0;
			end
			poarl_pkg::MODE_RAMP: begin
				if (!q_item.armed) step_mode = poarl_pkg::MODE_OFF;
				else if (step_el >= {8'd0, ramp_span}) step_mode = poarl_pkg::MODE_ON;
			end
			default: if (!q_item.armed) step_mode = poarl_pkg::MODE_OFF;
		endcase
	end

	assign mode_now  = lmode_q;
	assign out_channel = it_q.channel;
	assign d    = (it_q.dis > it_q.mn) ? it_q.mn : it_q.dis;
	assign diff = it_q.mn - d;
	assign rsh  = {rem_q, num_q[45]};
	assign rev  = ({28'd0, it_q.channel} < 32'(MAX_CHANNELS)) && rev_bits[it_q.channel];
	assign qprod = 53'(prod_q[29:4]) * 53'(poarl_pkg::PROG_RECIP);
	assign numv = 36'(mul_q) + $signed({5'd0, mid_q, 15'd0});
	assign mag  = numv[35] ? 36'(-numv) : numv;
	assign res_tr = numv[35] ? (32'd0 - 32'(mag >> 15)) : 32'(mag >> 15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= poarl_pkg::ST_IDLE;
			lmode_q <= poarl_pkg::MODE_INIT;
			fmode_q <= poarl_pkg::MODE_INIT;
			arm_q   <= 32'd0;
			prog_q  <= 14'd0;
		end else begin
			st_q <= st_nx;
			if (st_q == poarl_pkg::ST_IDLE && q_valid && q_item.start) begin
				lmode_q <= step_mode;
				fmode_q <= q_item.prearm ? poarl_pkg::MODE_ON : step_mode;
				arm_q   <= step_arm;
			end
			if (st_q == poarl_pkg::ST_DIV && dcnt_q == 6'd0) begin
				if (ramp_span == 24'd0 || num_q[45:0] > 46'd10000)
					prog_q <= 14'(poarl_pkg::PROGRESS_FULL);
				else
					prog_q <= num_q[13:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == poarl_pkg::ST_IDLE && q_valid) begin
			it_q   <= q_item;
			rem_q  <= 24'd0;
			dcnt_q <= 6'd46;
			num_q  <= 46'(step_el) * 46'(poarl_pkg::PROGRESS_FULL);
		end
		if (st_q == poarl_pkg::ST_DIV && dcnt_q != 6'd0) begin
			// restoring division, one quotient bit per cycle
			dcnt_q <= dcnt_q - 6'd1;
			if (rsh >= {1'b0, ramp_span}) begin
				rem_q <= 24'(rsh - {1'b0, ramp_span});
				num_q <= {num_q[44:0], 1'b1};
			end else begin
				rem_q <= rsh[23:0];
				num_q <= {num_q[44:0], 1'b0};
			end
		end
		if (st_q == poarl_pkg::ST_LO1) begin
			prod_q <= 30'(diff) * 30'(prog_q);
		end
		if (st_q == poarl_pkg::ST_LO2) begin
			// divide by 10000 through the reciprocal
			quo_q <= qprod[poarl_pkg::PROG_RECIP_SHIFT +: 16];
		end
		if (st_q == poarl_pkg::ST_LO3) begin
			logic [15:0] lo;
			lo = it_q.mn;
			if (fmode_q == poarl_pkg::MODE_RAMP && it_q.dis != 16'd0)
				lo = d + quo_q;
			lo_q   <= lo;
			half_q <= 17'(($signed({1'b0, it_q.mx}) - $signed({1'b0, lo})) / 17'sd2);
			mid_q  <= 16'(({1'b0, it_q.mx} + {1'b0, lo}) >> 1);
			v_q    <= rev ? -17'(it_q.ctrl) : 17'(it_q.ctrl);
		end
		if (st_q == poarl_pkg::ST_MUL) begin
			mul_q <= 35'(v_q * half_q);
		end
		if (st_q == poarl_pkg::ST_FIN) begin
			if ((fmode_q != poarl_pkg::MODE_RAMP && fmode_q != poarl_pkg::MODE_ON)
			    || !it_q.valid)
				pwm_value <= it_q.dis;
			else if ($signed(res_tr) < $signed({16'd0, lo_q}))
				pwm_value <= lo_q;
			else if ($signed(res_tr) > $signed({16'd0, it_q.mx}))
				pwm_value <= it_q.mx;
			else
				pwm_value <= res_tr[15:0];
		end
	end
endmodule
`default_nettype wire

// File: bench/tb_pwm_output_arming_ramp_limiter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pwm_output_arming_ramp_limiter: self-checking bench for the arming limiter
// Drives frames of channel items through the stream input. A scoreboard class
// holds its own copy of the arming machine and the PWM mapping, works out the
// expected word for every transfer taken in, and compares each transfer out
// field by field. Registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_pwm_output_arming_ramp_limiter;

	// One expected output word.
	typedef struct {
		logic [3:0]  chan;
		logic [15:0] pwm;
		logic [1:0]  mode;
	} pwm_word_t;

	// Scoreboard: arming/ramp predictor plus the queue of expected words.
	class pwm_scoreboard;
		logic [15:0] rev_mask;
		logic [31:0] ramp_us;
		logic [31:0] init_us;
		poarl_pkg::mode_t arm_mode;
		logic [31:0] armed_at;
		logic [31:0] progress;
		poarl_pkg::mode_t cur_frame_mode;
		pwm_word_t   pending[$];
		int          errors;

		function void reset_state();
			rev_mask = 0;
			ramp_us = 500000;
			init_us = 500000;
			arm_mode = poarl_pkg::MODE_INIT;
			armed_at = 0;
			progress = 0;
			cur_frame_mode = poarl_pkg::MODE_INIT;
			pending.delete();
			errors = 0;
		endfunction

		function void write_reg(poarl_pkg::reg_idx_t idx, logic [23:0] val);
			case (idx)
				poarl_pkg::REG_REVERSE: rev_mask = val[15:0];
				poarl_pkg::REG_RAMP: ramp_us = {8'd0, val};
				poarl_pkg::REG_INIT: init_us = {8'd0, val};
				default: ;
			endcase
		endfunction

		// Arming machine step, taken on the frame start item.
		function void step_frame(bit armed, bit pre, logic [31:0] now);
			logic [31:0] elapsed;
			longint unsigned p;
			case (arm_mode)
				poarl_pkg::MODE_INIT: if (armed) begin
					if (armed_at == 0) armed_at = now;
					if (32'(now - armed_at) >= init_us) arm_mode = poarl_pkg::MODE_OFF;
				end
				poarl_pkg::MODE_OFF: if (armed) begin
					arm_mode = poarl_pkg::MODE_RAMP;
					armed_at = now;
				end
				poarl_pkg::MODE_RAMP: begin
					if (!armed) arm_mode = poarl_pkg::MODE_OFF;
					else if (32'(now - armed_at) >= ramp_us) arm_mode = poarl_pkg::MODE_ON;
				end
				default: if (!armed) arm_mode = poarl_pkg::MODE_OFF;
			endcase
			cur_frame_mode = pre ? poarl_pkg::MODE_ON : arm_mode;
			elapsed = now - armed_at;
			if (ramp_us == 0) begin
				progress = poarl_pkg::PROGRESS_FULL;
			end else begin
				p = (64'(elapsed) * poarl_pkg::PROGRESS_FULL) / ramp_us;
				progress = (p > poarl_pkg::PROGRESS_FULL) ? poarl_pkg::PROGRESS_FULL : 32'(p);
			end
		endfunction

		function logic [15:0] scale_pwm(logic [3:0] ch, logic signed [15:0] cv,
				logic [15:0] dis, logic [15:0] mn, logic [15:0] mx);
			longint lo, d, half, num, res, v;
			lo = mn;
			if (cur_frame_mode == poarl_pkg::MODE_RAMP && dis > 0) begin
				d = (dis > mn) ? mn : dis;
				lo = d + ((mn - d) * progress) / poarl_pkg::PROGRESS_FULL;
			end
			v = cv;
			if (rev_mask[ch]) v = -v;     // negating -1.0 yields +1.0
			half = (longint'(mx) - lo) / 2;
			num = v * half + ((longint'(mx) + lo) >>> 1) * 32768;
			res = (num >= 0) ? (num >>> 15) : -((-num) >>> 15);
			if (res < lo) return lo[15:0];
			if (res > mx) return mx;
			return res[15:0];
		endfunction

		function void note_input(poarl_pkg::item_t it);
			pwm_word_t w;
			if (it.start) step_frame(it.armed, it.prearm, it.now_us);
			w.chan = it.channel;
			if ((cur_frame_mode != poarl_pkg::MODE_RAMP && cur_frame_mode != poarl_pkg::MODE_ON)
			    || !it.valid)
				w.pwm = it.dis;
			else
				w.pwm = scale_pwm(it.channel, it.ctrl, it.dis, it.mn, it.mx);
			w.mode = arm_mode;
			pending.push_back(w);
		endfunction

		function void check_output(logic [23:0] t);
			pwm_word_t w;
			if (pending.size() == 0) begin
				$error("unexpected output transfer %h", t);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (t[3:0] !== w.chan) begin
				$error("out_channel: expected %0d, got %0d", w.chan, t[3:0]);
				errors++;
			end
			if (t[19:4] !== w.pwm) begin
				$error("pwm_value: expected %0d, got %0d", w.pwm, t[19:4]);
				errors++;
			end
			if (t[21:20] !== w.mode) begin
				$error("mode_now: expected %0d, got %0d", w.mode, t[21:20]);
				errors++;
			end
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	// frame_start, armed, prearm, now_us, channel, ctrl,
	// value_valid, disarmed_level, min_level, max_level
	logic [103:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	// out_channel, pwm_value, mode_now, zero fill
	logic [23:0]  m_axis_tdata;
	logic         cfg_we = 0;
	logic [1:0]   cfg_index = '0;
	logic [23:0]  cfg_data = '0;

	pwm_scoreboard sb;
	int  idle_pct = 28;      // idling chance in percent, both sides
	int  stall_cycles = 0;
	logic [31:0] clock_us = 0;  // stimulus time base

	localparam int STALL_LIMIT = 5000;

	pwm_output_arming_ramp_limiter dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// Receiver: random backpressure, check on each output transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
			m_axis_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// Watchdog: cycles without any transfer.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("tb_pwm_output_arming_ramp_limiter failed");
			$finish;
		end
	end

	// Valid stays high from one transfer to the next unless an idle cycle comes.
	task automatic send_item(bit start, bit armed, bit pre, logic [31:0] now,
			logic [3:0] ch, logic [15:0] cv, bit valid, logic [15:0] dis,
			logic [15:0] mn, logic [15:0] mx);
		poarl_pkg::item_t it;
		it = '{start, armed, pre, now, ch, cv, valid, dis, mn, mx};
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {mx, mn, dis, valid, cv, ch, now, pre, armed, start};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(it);
	endtask

	// Hold off until every expected word is back, plus the frame latency.
	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_reg(poarl_pkg::reg_idx_t idx, logic [23:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// Random frame of 1..16 channels; limits biased toward sane ordering.
	task automatic random_frame(bit armed, logic [31:0] dt);
		int n;
		logic [15:0] mn, mx, dis;
		clock_us = clock_us + dt;
		n = $urandom_range(1, 16);
		for (int c = 0; c < n; c++) begin
			mn = $urandom_range(0, 65535);
			mx = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(mn, 65535));
			dis = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom);
			send_item(c == 0, ($urandom_range(19) == 0) ? !armed : armed,
				$urandom_range(15) == 0, clock_us, c[3:0], 16'($urandom),
				$urandom_range(9) != 0, dis, mn, mx);
		end
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: items before any frame start give the disarmed level.
		send_item(0, 1, 0, 32'd5, 4'd3, 16'h7FFF, 1, 16'd1500, 16'd1000, 16'd2000);
		// Arming at time zero leaves the arm time unset.
		send_item(1, 1, 0, 32'd0, 4'd0, 16'h8000, 1, 16'd900, 16'd1000, 16'd2000);
		drain();
		set_reg(poarl_pkg::REG_INIT, 24'd0);
		set_reg(poarl_pkg::REG_RAMP, 24'd1000);
		set_reg(poarl_pkg::REG_REVERSE, 24'h00FFFF);
		// init -> off, off -> ramp, then a ramp frame, then on
		send_item(1, 1, 0, 32'd10, 4'd0, 16'h8000, 1, 16'd900, 16'd1000, 16'd2000);
		send_item(1, 1, 0, 32'd20, 4'd0, 16'h8000, 1, 16'd900, 16'd1000, 16'd2000);
		send_item(1, 1, 0, 32'd520, 4'd15, 16'h8000, 1, 16'd900, 16'd1000, 16'd2000);
		send_item(0, 0, 1, 32'hFFFFFFFF, 4'd1, 16'h7FFF, 1, 16'd0, 16'd1000, 16'd2000);
		send_item(0, 0, 0, 32'd0, 4'd2, 16'h0000, 0, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_item(0, 0, 0, 32'd0, 4'd3, 16'h8000, 1, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_item(1, 1, 0, 32'd2000, 4'd0, 16'h7FFF, 1, 16'd0, 16'd0, 16'hFFFF);
		send_item(0, 1, 0, 32'd0, 4'd4, 16'h8000, 1, 16'd0, 16'd0, 16'hFFFF);
		// disarm while the pre-armed flag forces on for one frame, then plain disarm
		send_item(1, 0, 1, 32'd2100, 4'd0, 16'h4000, 1, 16'd100, 16'd200, 16'd300);
		send_item(1, 0, 0, 32'd2200, 4'd0, 16'h4000, 1, 16'd100, 16'd200, 16'd300);
		// timestamp wrap through a ramp
		send_item(1, 1, 0, 32'hFFFFFF00, 4'd0, 16'hC000, 1, 16'd500, 16'd800, 16'd900);
		send_item(1, 1, 0, 32'h00000100, 4'd5, 16'h2000, 1, 16'd500, 16'd800, 16'd900);
		drain();

		// Random phases over several register settings, extremes included.
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					set_reg(poarl_pkg::REG_RAMP, 24'd1);
					set_reg(poarl_pkg::REG_INIT, 24'hFFFFFF);
				end
				1: begin
					set_reg(poarl_pkg::REG_RAMP, 24'hFFFFFF);
					set_reg(poarl_pkg::REG_INIT, 24'd100);
				end
				2: set_reg(poarl_pkg::REG_REVERSE, 24'h000000);
				default: begin
					set_reg(poarl_pkg::REG_REVERSE, 24'($urandom_range(0, 65535)));
					set_reg(poarl_pkg::REG_RAMP, 24'($urandom_range(1, 20000)));
					set_reg(poarl_pkg::REG_INIT, 24'($urandom_range(0, 20000)));
				end
			endcase
			idle_pct = (ph == 4) ? 0 : 28;
			clock_us = $urandom;
			for (int f = 0; f < 12; f++)
				random_frame($urandom_range(4) != 0,
					($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 30000));
			drain();
		end

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_pwm_output_arming_ramp_limiter passed");
		else
			$display("tb_pwm_output_arming_ramp_limiter failed");
		$finish;
	end
endmodule
`default_nettype wire
